[design/rcoc_pkg.sv]
// shared types, constants and grid geometry for the rectangle coverage overlap counter
// no dependencies; imported by every module of the block
`default_nettype none

package rcoc_pkg;

  // grid geometry
  localparam int GRID_WIDTH  = 1024;
  localparam int GRID_HEIGHT = 1024;
  localparam int CELL_COUNT  = GRID_WIDTH * GRID_HEIGHT;
  localparam int ADDR_W      = $clog2(CELL_COUNT);

  // transaction field widths
  localparam int OP_W    = 2;
  localparam int POS_W   = 10;
  localparam int SPAN_W  = 11;
  localparam int TOTAL_W = 21;
  localparam int COVER_W = 2;

  // column / row counters must hold the exclusive end (up to start + span or the grid size)
  localparam int XE_W = ($clog2(GRID_WIDTH + 1) > 12) ? $clog2(GRID_WIDTH + 1) : 12;
  localparam int YE_W = ($clog2(GRID_HEIGHT + 1) > 12) ? $clog2(GRID_HEIGHT + 1) : 12;

  // coverage counter levels
  localparam logic [COVER_W-1:0] COVER_ONE  = COVER_W'(1);
  localparam logic [COVER_W-1:0] COVER_FULL = COVER_W'(2);

  typedef enum logic [OP_W-1:0] {
    OP_PAINT = 2'd0,
    OP_CHECK = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_e;

  // per-cycle control from the sequencer to the cell unit
  typedef struct packed {
    logic              look;   // read data for a walked cell arrives this cycle
    logic              paint;  // walk is a paint, otherwise a check
    logic [ADDR_W-1:0] addr;   // address of the cell whose data arrives
    logic              zero;   // clear the overlap count
    logic              arm;    // start of a check: assume isolated
  } step_t;

  // result qualifiers from the sequencer
  typedef struct packed {
    logic valid;
    logic check;
    logic clipped;
  } res_t;

endpackage

`default_nettype wire

[design/rcoc_grid_ram.sv]
// coverage grid memory: one write port, one read port with registered read data
// depends on rcoc_pkg for grid size and cell width
`default_nettype none

module rcoc_grid_ram (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [rcoc_pkg::ADDR_W-1:0]       waddr_i,
  input  logic [rcoc_pkg::COVER_W-1:0]      wdata_i,
  input  logic                              re_i,
  input  logic [rcoc_pkg::ADDR_W-1:0]       raddr_i,
  output logic [rcoc_pkg::COVER_W-1:0]      rdata_o
);
  import rcoc_pkg::*;

  logic [COVER_W-1:0] mem [CELL_COUNT];
  logic [COVER_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[design/rcoc_cell_alu.sv]
// shared cell unit: saturating coverage increment, overlap count and isolation flag
// depends on rcoc_pkg for step_t and widths
`default_nettype none

module rcoc_cell_alu (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rcoc_pkg::step_t                   step_i,
  input  logic [rcoc_pkg::COVER_W-1:0]      rdata_i,
  output logic                              we_o,
  output logic [rcoc_pkg::ADDR_W-1:0]       waddr_o,
  output logic [rcoc_pkg::COVER_W-1:0]      wdata_o,
  output logic [rcoc_pkg::TOTAL_W-1:0]      total_o,
  output logic                              iso_o
);
  import rcoc_pkg::*;

  logic [TOTAL_W-1:0] total_q, total_d;
  logic               iso_q, iso_d;
  logic               below;
  logic               bump;

  // cell update and count
  always_comb begin
    below   = rdata_i < COVER_FULL;
    we_o    = step_i.look & step_i.paint & below;
    waddr_o = step_i.addr;
    wdata_o = rdata_i + COVER_W'(1);
    bump    = we_o && (rdata_i == COVER_ONE) && (total_q != {TOTAL_W{1'b1}});

    total_d = total_q;
    if (step_i.zero) begin
      total_d = '0;
    end else if (bump) begin
      total_d = total_q + TOTAL_W'(1);
    end

    iso_d = iso_q;
    if (step_i.arm) begin
      iso_d = 1'b1;
    end else if (step_i.look && !step_i.paint && !below) begin
      iso_d = 1'b0;
    end
  end

  // overlap count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else begin
      total_q <= total_d;
    end
  end

  // isolation flag
  always_ff @(posedge clk_i) begin
    iso_q <= iso_d;
  end

  assign total_o = total_q;
  assign iso_o   = iso_q;

endmodule

`default_nettype wire

[design/rcoc_seq.sv]
// sequencer: clipping, cell address walk, clearing sweep and result timing
// depends on rcoc_pkg for state_e, opcode_e, step_t, res_t and geometry
`default_nettype none

module rcoc_seq (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [rcoc_pkg::OP_W-1:0]         opcode_i,
  input  logic [rcoc_pkg::POS_W-1:0]        left_i,
  input  logic [rcoc_pkg::POS_W-1:0]        top_i,
  input  logic [rcoc_pkg::SPAN_W-1:0]       width_i,
  input  logic [rcoc_pkg::SPAN_W-1:0]       height_i,
  output logic                              ram_re_o,
  output logic [rcoc_pkg::ADDR_W-1:0]       ram_raddr_o,
  output logic                              sweep_we_o,
  output logic [rcoc_pkg::ADDR_W-1:0]       sweep_addr_o,
  output rcoc_pkg::step_t                   step_o,
  output rcoc_pkg::res_t                    res_o
);
  import rcoc_pkg::*;

  state_e            state_q, state_d;
  logic              report_q, report_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic              look_q, look_d;
  logic [ADDR_W-1:0] look_addr_q;
  logic              paint_q, paint_d;
  logic              check_q, check_d;
  logic              clipped_q, clipped_d;
  logic [XE_W-1:0]   x0_q, x0_d, x1_q, x1_d, x_q, x_d;
  logic [YE_W-1:0]   y1_q, y1_d, y_q, y_d;
  logic [ADDR_W-1:0] row_q, row_d;

  logic [XE_W-1:0]   x_sum, x_end, x_start;
  logic [YE_W-1:0]   y_sum, y_end, y_start;
  logic              clip_x, clip_y, nonempty;
  logic [ADDR_W-1:0] base;

  // clip the incoming rectangle against the grid
  always_comb begin
    x_start = XE_W'(left_i);
    y_start = YE_W'(top_i);
    x_sum   = x_start + XE_W'(width_i);
    y_sum   = y_start + YE_W'(height_i);
    clip_x  = x_sum > XE_W'(GRID_WIDTH);
    clip_y  = y_sum > YE_W'(GRID_HEIGHT);
    x_end   = clip_x ? XE_W'(GRID_WIDTH) : x_sum;
    y_end   = clip_y ? YE_W'(GRID_HEIGHT) : y_sum;
    if (x_start > x_end) begin
      x_end = x_start;
    end
    if (y_start > y_end) begin
      y_end = y_start;
    end
    nonempty = (x_start < x_end) && (y_start < y_end);
    base     = ADDR_W'(top_i) * ADDR_W'(GRID_WIDTH) + ADDR_W'(left_i);
  end

  // next state and outputs
  always_comb begin
    state_d   = state_q;
    report_d  = report_q;
    addr_d    = addr_q;
    paint_d   = paint_q;
    check_d   = check_q;
    clipped_d = clipped_q;
    x0_d      = x0_q;
    x1_d      = x1_q;
    y1_d      = y1_q;
    x_d       = x_q;
    y_d       = y_q;
    row_d     = row_q;

    busy        = state_q != ST_IDLE;
    ram_re_o    = 1'b0;
    sweep_we_o  = 1'b0;
    step_o.zero = 1'b0;
    step_o.arm  = 1'b0;
    res_o.valid = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (opcode_e'(opcode_i))
            OP_PAINT, OP_CHECK: begin
              paint_d    = opcode_e'(opcode_i) == OP_PAINT;
              check_d    = opcode_e'(opcode_i) == OP_CHECK;
              step_o.arm = opcode_e'(opcode_i) == OP_CHECK;
              clipped_d  = clip_x | clip_y;
              x0_d       = x_start;
              x1_d       = x_end;
              y1_d       = y_end;
              x_d        = x_start;
              y_d        = y_start;
              row_d      = base;
              addr_d     = base;
              state_d    = nonempty ? ST_WALK : ST_DONE;
            end
            OP_CLEAR: begin
              step_o.zero = 1'b1;
              report_d    = 1'b1;
              addr_d      = '0;
              check_d     = 1'b0;
              clipped_d   = 1'b0;
              state_d     = ST_CLEAR;
            end
            default: begin
              check_d   = 1'b0;
              clipped_d = 1'b0;
              state_d   = ST_DONE;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        // one cell zeroed per cycle
        sweep_we_o = 1'b1;
        addr_d     = addr_q + ADDR_W'(1);
        if (addr_q == ADDR_W'(CELL_COUNT - 1)) begin
          state_d = report_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_WALK: begin
        // row-major walk, one cell read per cycle
        ram_re_o = 1'b1;
        if ((x_q + XE_W'(1)) == x1_q) begin
          if ((y_q + YE_W'(1)) == y1_q) begin
            state_d = ST_DRAIN;
          end else begin
            y_d    = y_q + YE_W'(1);
            x_d    = x0_q;
            row_d  = row_q + ADDR_W'(GRID_WIDTH);
            addr_d = row_q + ADDR_W'(GRID_WIDTH);
          end
        end else begin
          x_d    = x_q + XE_W'(1);
          addr_d = addr_q + ADDR_W'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        res_o.valid = 1'b1;
        report_d    = 1'b0;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    look_d        = state_q == ST_WALK;
    ram_raddr_o   = addr_q;
    sweep_addr_o  = addr_q;
    step_o.look   = look_q;
    step_o.paint  = paint_q;
    step_o.addr   = look_addr_q;
    res_o.check   = check_q;
    res_o.clipped = clipped_q;
  end

  // control registers; reset starts the clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      report_q <= 1'b0;
      addr_q   <= '0;
      look_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      report_q <= report_d;
      addr_q   <= addr_d;
      look_q   <= look_d;
    end
  end

  // walk bounds and result qualifiers
  always_ff @(posedge clk_i) begin
    look_addr_q <= addr_q;
    paint_q     <= paint_d;
    check_q     <= check_d;
    clipped_q   <= clipped_d;
    x0_q        <= x0_d;
    x1_q        <= x1_d;
    y1_q        <= y1_d;
    x_q         <= x_d;
    y_q         <= y_d;
    row_q       <= row_d;
  end

endmodule

`default_nettype wire

[design/rectangle_coverage_overlap_counter_top.sv]
// top level of the rectangle coverage overlap counter
// depends on rcoc_pkg, rcoc_seq, rcoc_cell_alu and rcoc_grid_ram
//
// channel   direction  handshake             payload
// command   in         start, busy           opcode_i, left_i, top_i, width_i, height_i
// result    out        done_o (one cycle)    overlap_cells_o, isolated_o, clipped_o
//
// paint / check: one grid cell per cycle through the single memory read port; after the
//   walk over the clipped rectangle a drain state follows, then done_o
// empty rectangle and no-op: done_o in the cycle after the command is taken
// clear: one cell zeroed per cycle over the whole grid, then done_o
// after reset the same clearing sweep runs with busy high
// results cannot be held off by the receiver
`default_nettype none

module rectangle_coverage_overlap_counter_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [rcoc_pkg::OP_W-1:0]         opcode_i,
  input  logic [rcoc_pkg::POS_W-1:0]        left_i,
  input  logic [rcoc_pkg::POS_W-1:0]        top_i,
  input  logic [rcoc_pkg::SPAN_W-1:0]       width_i,
  input  logic [rcoc_pkg::SPAN_W-1:0]       height_i,
  output logic                              done_o,
  output logic [rcoc_pkg::TOTAL_W-1:0]      overlap_cells_o,
  output logic                              isolated_o,
  output logic                              clipped_o
);
  import rcoc_pkg::*;

  step_t              step;
  res_t               res;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [COVER_W-1:0] ram_rdata;
  logic               sweep_we;
  logic [ADDR_W-1:0]  sweep_addr;
  logic               alu_we;
  logic [ADDR_W-1:0]  alu_waddr;
  logic [COVER_W-1:0] alu_wdata;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [COVER_W-1:0] ram_wdata;
  logic [TOTAL_W-1:0] total;
  logic               iso;

  rcoc_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .opcode_i     (opcode_i),
    .left_i       (left_i),
    .top_i        (top_i),
    .width_i      (width_i),
    .height_i     (height_i),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .sweep_we_o   (sweep_we),
    .sweep_addr_o (sweep_addr),
    .step_o       (step),
    .res_o        (res)
  );

  rcoc_cell_alu u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .rdata_i (ram_rdata),
    .we_o    (alu_we),
    .waddr_o (alu_waddr),
    .wdata_o (alu_wdata),
    .total_o (total),
    .iso_o   (iso)
  );

  // write port: clearing sweep or cell update
  always_comb begin
    ram_we    = sweep_we | alu_we;
    ram_waddr = sweep_we ? sweep_addr : alu_waddr;
    ram_wdata = sweep_we ? '0 : alu_wdata;
  end

  rcoc_grid_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // result transaction
  assign done_o          = res.valid;
  assign overlap_cells_o = total;
  assign isolated_o      = res.check & iso;
  assign clipped_o       = res.clipped;

`ifndef ASSERT_OFF
  // a cell update never lands on the cell being read in the same cycle
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("grid write and read hit the same cell");

  // sweep and cell updates never compete for the write port
  a_single_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sweep_we && alu_we))
    else $error("clearing sweep and cell update write together");

  // a result is followed by an idle cycle that can take a command
  a_idle_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("block still busy after its result");

  // a result only follows a busy cycle or a taken command
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy || start))
    else $error("result without a command");
`endif

endmodule

`default_nettype wire
